// ----- design/npick_pkg.sv -----
// shared types and constants for the nearest pick hit extractor
package npick_pkg;

    localparam logic [31:0] DEPTH_INIT  = 32'hffff_ffff;
    localparam int          COUNT_WIDTH = 7;

    typedef struct packed {
        logic [31:0] word;
        logic        last_word;
    } t_item;

    typedef struct packed {
        logic [31:0]            hit_name;
        logic                   name_valid;
        logic [COUNT_WIDTH-1:0] name_count;
        logic                   truncated;
        logic                   last_result;
    } t_result;

    typedef enum logic [1:0] {
        PH_COUNT = 2'd0,
        PH_MIN   = 2'd1,
        PH_MAX   = 2'd2,
        PH_NAMES = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        ST_SCAN,
        ST_CALC,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic take;
        logic calc;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic emit_done;
    } t_dp_stat;

endpackage

// ----- design/npick_dp.sv -----
// datapath: record parser, best-hit registers, name store and result register
module npick_dp
    import npick_pkg::*;
#(
    parameter int MAX_NAMES = 16
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_item    i_item,
    input  t_dp_cmd  i_cmd,
    output t_dp_stat o_stat,
    output logic     o_strobe,
    output t_result  o_result
);

    localparam int IW = (MAX_NAMES > 1) ? $clog2(MAX_NAMES) : 1;
    localparam int CW = $clog2(MAX_NAMES + 1);

    t_phase      r_phase, n_phase;
    logic [31:0] r_record_count, n_record_count;
    logic [31:0] r_names_left, n_names_left;
    logic        r_record_is_best, n_record_is_best;
    logic [31:0] r_best_depth, n_best_depth;
    logic [31:0] r_best_count, n_best_count;
    logic [CW-1:0] r_k, n_k;
    logic [CW-1:0] r_n;
    logic          r_trunc;
    logic [31:0]   r_names [MAX_NAMES];
    logic [31:0]   r_rd_data;
    logic          r_strobe;
    t_result       r_result;

    logic [31:0]   pos;
    logic          wr_en;
    logic [31:0]   stored;
    logic [CW-1:0] n_calc;
    logic          trunc_calc;
    logic [CW-1:0] k_inc;
    logic          emit_done;
    logic [IW-1:0] rd_addr;

    assign pos        = r_record_count - r_names_left;
    assign wr_en      = i_cmd.take && (r_phase == PH_NAMES) && r_record_is_best
                        && (pos < 32'(MAX_NAMES));
    assign stored     = (r_record_is_best && (r_phase != PH_COUNT))
                        ? (r_best_count - r_names_left) : r_best_count;
    assign n_calc     = (stored < 32'(MAX_NAMES)) ? stored[CW-1:0] : CW'(MAX_NAMES);
    assign trunc_calc = r_best_count > 32'(MAX_NAMES);
    assign k_inc      = r_k + 1'b1;
    assign emit_done  = (r_n == '0) || (k_inc == r_n);
    assign rd_addr    = i_cmd.calc ? '0 : k_inc[IW-1:0];

    assign o_stat.emit_done = emit_done;
    assign o_strobe         = r_strobe;
    assign o_result         = r_result;

    always_comb begin
        n_phase          = r_phase;
        n_record_count   = r_record_count;
        n_names_left     = r_names_left;
        n_record_is_best = r_record_is_best;
        n_best_depth     = r_best_depth;
        n_best_count     = r_best_count;
        n_k              = r_k;
        if (i_cmd.take) begin
            case (r_phase)
                PH_COUNT: begin
                    n_record_count   = i_item.word;
                    n_names_left     = i_item.word;
                    n_record_is_best = 1'b0;
                    n_phase          = PH_MIN;
                end
                PH_MIN: begin
                    // strict compare keeps the first record at a tied depth
                    if (i_item.word < r_best_depth) begin
                        n_best_depth     = i_item.word;
                        n_best_count     = r_record_count;
                        n_record_is_best = 1'b1;
                    end
                    n_phase = PH_MAX;
                end
                PH_MAX: begin
                    n_phase = (r_names_left == '0) ? PH_COUNT : PH_NAMES;
                end
                PH_NAMES: begin
                    n_names_left = r_names_left - 1'b1;
                    if (r_names_left == 32'd1) begin
                        n_phase = PH_COUNT;
                    end
                end
                default: begin
                    n_phase = PH_COUNT;
                end
            endcase
        end
        if (i_cmd.calc) begin
            n_k = '0;
        end
        if (i_cmd.emit) begin
            n_k = k_inc;
            if (emit_done) begin
                // buffer finished, back to reset values for the next one
                n_phase          = PH_COUNT;
                n_record_count   = '0;
                n_names_left     = '0;
                n_record_is_best = 1'b0;
                n_best_depth     = DEPTH_INIT;
                n_best_count     = '0;
                n_k              = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase          <= PH_COUNT;
            r_record_count   <= '0;
            r_names_left     <= '0;
            r_record_is_best <= 1'b0;
            r_best_depth     <= DEPTH_INIT;
            r_best_count     <= '0;
            r_k              <= '0;
            r_strobe         <= 1'b0;
        end else begin
            r_phase          <= n_phase;
            r_record_count   <= n_record_count;
            r_names_left     <= n_names_left;
            r_record_is_best <= n_record_is_best;
            r_best_depth     <= n_best_depth;
            r_best_count     <= n_best_count;
            r_k              <= n_k;
            r_strobe         <= i_cmd.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.calc) begin
            r_n     <= n_calc;
            r_trunc <= trunc_calc;
        end
        if (i_cmd.emit) begin
            r_result.hit_name    <= (r_n == '0) ? 32'd0 : r_rd_data;
            r_result.name_valid  <= (r_n != '0);
            r_result.name_count  <= COUNT_WIDTH'(r_n);
            r_result.truncated   <= r_trunc;
            r_result.last_result <= emit_done;
        end
    end

    // name store, one write port and one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_names[pos[IW-1:0]] <= i_item.word;
        end
        if (32'(rd_addr) < 32'(MAX_NAMES)) begin
            r_rd_data <= r_names[rd_addr];
        end
    end

endmodule

// ----- design/npick_ctrl.sv -----
// controller: scan, count settle and emission sequencing
module npick_ctrl
    import npick_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  logic     i_last_word,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd,
    output logic     o_busy
);

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_SCAN: begin
                if (i_start && i_last_word) begin
                    n_state = ST_CALC;
                end
            end
            ST_CALC: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_stat.emit_done) begin
                    n_state = ST_SCAN;
                end
            end
            default: begin
                n_state = ST_SCAN;
            end
        endcase
    end

    always_comb begin
        o_cmd  = '0;
        o_busy = 1'b1;
        case (r_state)
            ST_SCAN: begin
                o_cmd.take = i_start;
                o_busy     = 1'b0;
            end
            ST_CALC: begin
                o_cmd.calc = 1'b1;
            end
            ST_EMIT: begin
                o_cmd.emit = 1'b1;
            end
            default: begin
                o_busy = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_SCAN;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- design/nearest_pick_hit_extractor_unit.sv -----
// Selection buffer words are taken one per cycle while o_busy is low: a transfer happens
// on each rising edge with i_start high and o_busy low. After the transfer of the word
// marked last_word the unit is busy: it first settles the name count and primes the read
// of the name store, then max(n, 1) results follow, where n is the number of stored names
// of the nearest hit; one result per cycle is emitted, paced by the store's single read
// port. Each result is shown for one cycle with o_strobe high and cannot be held off; the
// final result of a buffer appears in the cycle when o_busy has already dropped, so the
// next buffer's first word may be sent then.
module nearest_pick_hit_extractor_unit
    import npick_pkg::*;
#(
    parameter int MAX_NAMES = 16
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  t_item   i_item,
    output logic    o_busy,
    output logic    o_strobe,
    output t_result o_result
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    npick_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .i_last_word (i_item.last_word),
        .i_stat      (stat),
        .o_cmd       (cmd),
        .o_busy      (o_busy)
    );

    npick_dp #(
        .MAX_NAMES (MAX_NAMES)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_cmd    (cmd),
        .o_stat   (stat),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    // an empty result is always the only one of its buffer
    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_result.name_valid |-> o_result.last_result)
        else $error("empty result without last mark");

    // the last word of a buffer always starts an emission
    a_last_starts_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start && !o_busy && i_item.last_word |=> o_busy)
        else $error("last word did not start emission");

    // the unit is free again when the final result shows
    a_free_at_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_result.last_result |-> !o_busy)
        else $error("still busy at final result");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> 32'(o_result.name_count) <= 32'(MAX_NAMES))
        else $error("name count above store depth");

endmodule
